FILE: hdl/egaq_pkg.sv
package egaq_pkg;

  localparam int NumEntries = 16;
  localparam int NumLevels  = 4;
  localparam int ChanW      = 8;
  localparam int IdxW       = $clog2(NumEntries);
  localparam int LvlW       = $clog2(NumLevels);
  localparam int SqW        = 2 * ChanW;
  localparam int DistW      = SqW + 2;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [LvlW-1:0]  lvl_t;
  typedef logic [SqW-1:0]   sq_t;
  typedef logic [DistW-1:0] dist_t;

  typedef struct packed {
    chan_t in_red;
    chan_t in_green;
    chan_t in_blue;
  } in_pix_t;

  typedef struct packed {
    chan_t out_red;
    chan_t out_green;
    chan_t out_blue;
    idx_t  palette_index;
  } out_pix_t;

  localparam lvl_t LvlZero = 2'd0;
  localparam lvl_t LvlLow  = 2'd1;
  localparam lvl_t LvlMid  = 2'd2;
  localparam lvl_t LvlFull = 2'd3;

  localparam chan_t LEVELS [NumLevels] = '{8'd0, 8'd85, 8'd170, 8'd255};

  localparam lvl_t PAL_R [NumEntries] = '{
    LvlZero, LvlZero, LvlZero, LvlZero, LvlMid,  LvlMid,  LvlMid,  LvlMid,
    LvlLow,  LvlLow,  LvlLow,  LvlLow,  LvlFull, LvlFull, LvlFull, LvlFull
  };
  localparam lvl_t PAL_G [NumEntries] = '{
    LvlZero, LvlZero, LvlMid,  LvlMid,  LvlZero, LvlZero, LvlLow,  LvlMid,
    LvlLow,  LvlLow,  LvlFull, LvlFull, LvlLow,  LvlLow,  LvlFull, LvlFull
  };
  localparam lvl_t PAL_B [NumEntries] = '{
    LvlZero, LvlMid,  LvlZero, LvlMid,  LvlZero, LvlMid,  LvlZero, LvlMid,
    LvlLow,  LvlFull, LvlLow,  LvlFull, LvlLow,  LvlFull, LvlLow,  LvlFull
  };

  function automatic sq_t sq_diff(chan_t a, chan_t b);
    sq_t d;
    d = SqW'((a >= b) ? (a - b) : (b - a));
    return d * d;
  endfunction

endpackage

FILE: hdl/egaq_dist.sv
module egaq_dist (
  input  egaq_pkg::in_pix_t pix,
  output egaq_pkg::dist_t   sq_dist [egaq_pkg::NumEntries]
);

  egaq_pkg::sq_t sq_r_l [egaq_pkg::NumLevels];
  egaq_pkg::sq_t sq_g_l [egaq_pkg::NumLevels];
  egaq_pkg::sq_t sq_b_l [egaq_pkg::NumLevels];

  always_comb begin
    for (int l = 0; l < egaq_pkg::NumLevels; l++) begin
      sq_r_l[l] = egaq_pkg::sq_diff(egaq_pkg::LEVELS[l], pix.in_red);
      sq_g_l[l] = egaq_pkg::sq_diff(egaq_pkg::LEVELS[l], pix.in_green);
      sq_b_l[l] = egaq_pkg::sq_diff(egaq_pkg::LEVELS[l], pix.in_blue);
    end
  end

  always_comb begin
    for (int k = 0; k < egaq_pkg::NumEntries; k++) begin
      sq_dist[k] = egaq_pkg::DistW'(sq_r_l[egaq_pkg::PAL_R[k]])
                 + egaq_pkg::DistW'(sq_g_l[egaq_pkg::PAL_G[k]])
                 + egaq_pkg::DistW'(sq_b_l[egaq_pkg::PAL_B[k]]);
    end
  end

endmodule

FILE: hdl/egaq_argmin.sv
module egaq_argmin (
  input  egaq_pkg::dist_t sq_dist [egaq_pkg::NumEntries],
  output egaq_pkg::idx_t  best_idx
);

  localparam int Depth = egaq_pkg::IdxW;

  egaq_pkg::dist_t d_l   [Depth+1][egaq_pkg::NumEntries];
  egaq_pkg::idx_t  idx_l [Depth+1][egaq_pkg::NumEntries];

  // lower index sits on the left; right wins only when strictly smaller
  always_comb begin
    for (int l = 0; l <= Depth; l++) begin
      for (int i = 0; i < egaq_pkg::NumEntries; i++) begin
        d_l[l][i]   = '0;
        idx_l[l][i] = '0;
      end
    end
    for (int i = 0; i < egaq_pkg::NumEntries; i++) begin
      d_l[0][i]   = sq_dist[i];
      idx_l[0][i] = egaq_pkg::IdxW'(i);
    end
    for (int l = 1; l <= Depth; l++) begin
      for (int i = 0; i < egaq_pkg::NumEntries / 2; i++) begin
        if (i < (egaq_pkg::NumEntries >> l)) begin
          if (d_l[l-1][2*i+1] < d_l[l-1][2*i]) begin
            d_l[l][i]   = d_l[l-1][2*i+1];
            idx_l[l][i] = idx_l[l-1][2*i+1];
          end else begin
            d_l[l][i]   = d_l[l-1][2*i];
            idx_l[l][i] = idx_l[l-1][2*i];
          end
        end
      end
    end
  end

  assign best_idx = idx_l[Depth][0];

endmodule

FILE: hdl/nearest_ega16_color_quantizer.sv
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready    in_data   (egaq_pkg::in_pix_t)
// out      output     out_valid / out_ready  out_data  (egaq_pkg::out_pix_t)
//
// Two register stages: pixel register, then result register.
// One pixel per cycle sustained while out_ready is high; the distance and
// 16-way minimum tree between the stages set the clock period.
// Synchronous active-low reset clears both valid flags only.
// A stall at out_ready holds a full result stage and a full pixel stage behind it;
// in_ready follows out_ready combinationally.
module nearest_ega16_color_quantizer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  egaq_pkg::in_pix_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output egaq_pkg::out_pix_t  out_data
);

  egaq_pkg::in_pix_t  pix_r, pix_nxt;
  logic               pix_v_r, pix_v_nxt;
  egaq_pkg::out_pix_t res_r, res_nxt;
  logic               res_v_r, res_v_nxt;

  egaq_pkg::dist_t    sq_dist [egaq_pkg::NumEntries];
  egaq_pkg::idx_t     best_idx;
  logic               res_ready;

  egaq_dist u_dist (
    .pix     (pix_r),
    .sq_dist (sq_dist)
  );

  egaq_argmin u_argmin (
    .sq_dist  (sq_dist),
    .best_idx (best_idx)
  );

  assign res_ready = !res_v_r || out_ready;
  assign in_ready  = !pix_v_r || res_ready;

  always_comb begin
    pix_nxt   = pix_r;
    pix_v_nxt = pix_v_r;
    res_nxt   = res_r;
    res_v_nxt = res_v_r;
    if (res_ready) begin
      res_v_nxt = pix_v_r;
      res_nxt.out_red       = egaq_pkg::LEVELS[egaq_pkg::PAL_R[best_idx]];
      res_nxt.out_green     = egaq_pkg::LEVELS[egaq_pkg::PAL_G[best_idx]];
      res_nxt.out_blue      = egaq_pkg::LEVELS[egaq_pkg::PAL_B[best_idx]];
      res_nxt.palette_index = best_idx;
    end
    if (in_ready) begin
      pix_v_nxt = in_valid;
      pix_nxt   = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_v_r <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      pix_v_r <= pix_v_nxt;
      res_v_r <= res_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
    res_r <= res_nxt;
  end

  assign out_valid = res_v_r;
  assign out_data  = res_r;

endmodule

FILE: bench/egaq_result_checker.sv
`timescale 1ns / 100ps

module egaq_result_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  egaq_pkg::in_pix_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  egaq_pkg::out_pix_t out_data,
  output int                 mismatch_count,
  output int                 pending_results
);

  localparam logic [23:0] EGA_RGB [16] = '{
    24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
    24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
    24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
    24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
  };

  egaq_pkg::out_pix_t expected_colors [$];

  // strict less-than keeps the lowest index on a tie
  function automatic egaq_pkg::out_pix_t nearest_ega_color(egaq_pkg::in_pix_t px);
    int                 best_dist;
    int                 best;
    int                 cand_dist;
    int                 dr;
    int                 dg;
    int                 db;
    egaq_pkg::out_pix_t res;
    best_dist = 32'h7FFF_FFFF;
    best      = 0;
    for (int k = 0; k < 16; k++) begin
      dr        = int'(EGA_RGB[k][23:16]) - int'(px.in_red);
      dg        = int'(EGA_RGB[k][15:8]) - int'(px.in_green);
      db        = int'(EGA_RGB[k][7:0]) - int'(px.in_blue);
      cand_dist = dr * dr + dg * dg + db * db;
      if (cand_dist < best_dist) begin
        best_dist = cand_dist;
        best      = k;
      end
    end
    res.out_red       = EGA_RGB[best][23:16];
    res.out_green     = EGA_RGB[best][15:8];
    res.out_blue      = EGA_RGB[best][7:0];
    res.palette_index = egaq_pkg::idx_t'(best);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    egaq_pkg::out_pix_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) begin
          report_mismatch("unexpected transfer, index", out_data.palette_index, 0);
        end else begin
          want = expected_colors.pop_front();
          if (out_data.out_red !== want.out_red)
            report_mismatch("out_red", out_data.out_red, want.out_red);
          if (out_data.out_green !== want.out_green)
            report_mismatch("out_green", out_data.out_green, want.out_green);
          if (out_data.out_blue !== want.out_blue)
            report_mismatch("out_blue", out_data.out_blue, want.out_blue);
          if (out_data.palette_index !== want.palette_index)
            report_mismatch("palette_index", out_data.palette_index, want.palette_index);
        end
      end
      if (in_valid && in_ready)
        expected_colors.push_back(nearest_ega_color(in_data));
    end
    pending_results <= expected_colors.size();
  end

endmodule

FILE: bench/nearest_ega16_color_quantizer_tb.sv
`timescale 1ns / 100ps

module nearest_ega16_color_quantizer_tb;

  localparam int IdleLimit    = 1000;
  localparam int RandomPixels = 750;

  localparam egaq_pkg::chan_t BOUNDARY_LEVELS [10] = '{
    8'd0, 8'd42, 8'd43, 8'd85, 8'd127, 8'd128, 8'd170, 8'd212, 8'd213, 8'd255
  };

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  egaq_pkg::in_pix_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  egaq_pkg::out_pix_t out_data;

  int mismatch_count;
  int pending_results;
  int idle_cycles = 0;
  bit steady      = 1'b0;

  always #1 clk = ~clk;

  nearest_ega16_color_quantizer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  egaq_result_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  function automatic egaq_pkg::chan_t jitter(egaq_pkg::chan_t base);
    int v;
    v = int'(base) + int'($urandom_range(12, 0)) - 6;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return egaq_pkg::chan_t'(v);
  endfunction

  function automatic egaq_pkg::in_pix_t random_pixel();
    egaq_pkg::in_pix_t px;
    int                k;
    int                kind;
    kind = $urandom_range(9, 0);
    k    = $urandom_range(15, 0);
    if (kind < 4) begin
      px = egaq_pkg::in_pix_t'(24'($urandom));
    end else if (kind < 7) begin
      px.in_red   = jitter(egaq_pkg::LEVELS[egaq_pkg::PAL_R[k]]);
      px.in_green = jitter(egaq_pkg::LEVELS[egaq_pkg::PAL_G[k]]);
      px.in_blue  = jitter(egaq_pkg::LEVELS[egaq_pkg::PAL_B[k]]);
    end else if (kind < 9) begin
      px.in_red   = BOUNDARY_LEVELS[$urandom_range(9, 0)];
      px.in_green = BOUNDARY_LEVELS[$urandom_range(9, 0)];
      px.in_blue  = BOUNDARY_LEVELS[$urandom_range(9, 0)];
    end else begin
      px.in_red   = $urandom_range(1, 0) ? 8'hFF : 8'h00;
      px.in_green = $urandom_range(1, 0) ? 8'hFF : 8'h00;
      px.in_blue  = $urandom_range(1, 0) ? 8'hFF : 8'h00;
    end
    return px;
  endfunction

  task automatic send_pixel(egaq_pkg::in_pix_t px);
    int gap;
    gap = steady ? 0 : $urandom_range(7, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    egaq_pkg::in_pix_t px;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    for (int k = 0; k < 16; k++) begin
      px.in_red   = egaq_pkg::LEVELS[egaq_pkg::PAL_R[k]];
      px.in_green = egaq_pkg::LEVELS[egaq_pkg::PAL_G[k]];
      px.in_blue  = egaq_pkg::LEVELS[egaq_pkg::PAL_B[k]];
      send_pixel(px);
    end
    // ties between palette entries, then pure full-scale primaries
    send_pixel('{8'd85, 8'd0, 8'd0});
    send_pixel('{8'd0, 8'd0, 8'd85});
    send_pixel('{8'd0, 8'd85, 8'd0});
    send_pixel('{8'd170, 8'd0, 8'd85});
    send_pixel('{8'd255, 8'd0, 8'd0});
    send_pixel('{8'd0, 8'd255, 8'd0});
    send_pixel('{8'd0, 8'd0, 8'd255});
    for (int n = 0; n < RandomPixels; n++) begin
      steady = ((n / 50) % 4) == 3;
      send_pixel(random_pixel());
    end
    in_valid <= 1'b0;
    steady = 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    int stall;
    forever begin
      stall = steady ? 0 : $urandom_range(7, 0);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && rst_n));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
